// File: hw/rtl/c2e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2e_pkg
// Shared types, constants and lookup functions for the calendar to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

	localparam int unsigned SecsYear     = 31536000;
	localparam int unsigned SecsDay      = 86400;
	localparam int unsigned SecsHour     = 3600;
	localparam int unsigned SecsMinute   = 60;
	localparam int unsigned Secs1970To2000 = 946684800;
	localparam int unsigned CenturyOffset  = 100;

	localparam int SecW     = 6;
	localparam int MinW     = 6;
	localparam int HourW    = 5;
	localparam int DayW     = 5;
	localparam int MonW     = 4;
	localparam int YearW    = 7;
	localparam int EpochW   = 32;
	localparam int MonSecsW = 25;
	localparam int DaySecsW = 22;
	localparam int TodW     = 17;
	localparam int InDataW  = 40;

	localparam logic [MonW-1:0] MonFeb = 4'd2;
	localparam logic [MonW-1:0] MonDec = 4'd12;

	typedef logic [MonSecsW-1:0] mon_secs_arr_t [16];

	// seconds from Jan 1 to the first of each month, non-leap year, indexed by month
	localparam mon_secs_arr_t MonthStartSecs = '{
		25'd0,        25'd0,        25'd2678400,  25'd5097600,
		25'd7776000,  25'd10368000, 25'd13046400, 25'd15638400,
		25'd18316800, 25'd20995200, 25'd23587200, 25'd26265600,
		25'd28857600, 25'd0,        25'd0,        25'd0
	};

	typedef struct packed {
		logic [SecW-1:0]  second;
		logic [MinW-1:0]  minute;
		logic [HourW-1:0] hour;
		logic [DayW-1:0]  day_of_month;
		logic [MonW-1:0]  month;
		logic [YearW-1:0] year_offset;
	} reading_t;

	typedef struct packed {
		logic [EpochW-1:0]   year_secs;
		logic [MonSecsW-1:0] month_secs;
		logic [DaySecsW-1:0] day_secs;
		logic [TodW-1:0]     tod_secs;
		logic                invalid;
	} terms_t;

	function automatic logic is_leap(input logic [YearW-1:0] off);
		return (off[1:0] == 2'b00) && (off != YearW'(CenturyOffset));
	endfunction

	// seconds from 1970 to Jan 1 of year 2000 + off
	function automatic logic [EpochW-1:0] year_start_secs(input logic [YearW-1:0] off);
		logic [YearW-2:0]  leaps;
		logic [63:0]       acc;
		// off+3 reaches 130 for the largest offsets, so the sum is one bit wider
		leaps = (YearW-1)'(({1'b0, off} + 8'd3) >> 2);
		if (off > YearW'(CenturyOffset))
			leaps = leaps - 1'b1;
		acc = 64'(Secs1970To2000) + 64'(off) * 64'(SecsYear) + 64'(leaps) * 64'(SecsDay);
		return acc[EpochW-1:0];
	endfunction

endpackage : c2e_pkg
`default_nettype wire

// File: hw/rtl/calendar_to_epoch_seconds_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds_top
// Converts one real-time-clock reading into seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one reading per item; m_* carries one result per item.
//   Every accepted reading gives exactly one result, in order.
//   Pipeline: input register, lookup/scale register, sum register.
//   With no stall the reading moves through the three registers in turn,
//   and m_tvalid rises when it is held in the sum register.
//   Throughput is one item per cycle while m_tready is high; the three stages
//   work on three items at once and each stage moves when the one after it is free.
//   When the receiver holds m_tready low, the result stays on m_tdata and
//   m_tuser, the stages behind it fill, and s_tready drops once all are full.
//   s_tready is high whenever m_tready is high.
//   Reset clears all stage valid flags; no result is shown until a new
//   reading is accepted.
//   A month of zero or above 12, or a day of zero, sets m_tuser and gives zero seconds.
// ----------------------------------------------------------------------------
module calendar_to_epoch_seconds_top
	import c2e_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
	// month[25:22], year_offset[32:26], zero fill[39:33]
	input  wire logic [InDataW-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// epoch_seconds[31:0]
	output logic [EpochW-1:0]       m_tdata,
	// invalid[0]
	output logic                    m_tuser
);

	logic     v1_q, v2_q, v3_q;
	logic     en1, en2, en3;
	reading_t rd_s1;
	terms_t   terms_s2;

	assign en3 = !v3_q || m_tready;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign s_tready = en1;
	assign m_tvalid = v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) v1_q <= s_tvalid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			rd_s1.second       <= s_tdata[5:0];
			rd_s1.minute       <= s_tdata[11:6];
			rd_s1.hour         <= s_tdata[16:12];
			rd_s1.day_of_month <= s_tdata[21:17];
			rd_s1.month        <= s_tdata[25:22];
			rd_s1.year_offset  <= s_tdata[32:26];
		end
	end

	c2e_scale u_scale (
		.clk      (clk),
		.en       (en2 && v1_q),
		.rd       (rd_s1),
		.terms_s2 (terms_s2)
	);

	c2e_sum u_sum (
		.clk        (clk),
		.en         (en3 && v2_q),
		.terms      (terms_s2),
		.epoch_s3   (m_tdata),
		.invalid_s3 (m_tuser)
	);

endmodule : calendar_to_epoch_seconds_top
`default_nettype wire

// File: hw/rtl/c2e_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2e_scale
// Second stage: year and month lookups, validity check, and scaling of the
// day and time-of-day fields into seconds.
// ----------------------------------------------------------------------------
module c2e_scale
	import c2e_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en,
	input  wire reading_t rd,
	output terms_t        terms_s2
);

	terms_t                nxt;
	logic [MonSecsW-1:0]   mon_base;
	logic [DayW-1:0]       day_m1;
	logic                  bad;

	always_comb begin
		bad = (rd.month == '0) || (rd.month > MonDec) || (rd.day_of_month == '0);
		mon_base = MonthStartSecs[rd.month];
		// leap day counts once february is over
		if (is_leap(rd.year_offset) && (rd.month > MonFeb))
			mon_base = mon_base + MonSecsW'(SecsDay);
		day_m1 = rd.day_of_month - DayW'(1);

		nxt.year_secs  = year_start_secs(rd.year_offset);
		nxt.month_secs = mon_base;
		nxt.day_secs   = DaySecsW'(32'(day_m1) * SecsDay);
		nxt.tod_secs   = TodW'(32'(rd.hour) * SecsHour + 32'(rd.minute) * SecsMinute
			+ 32'(rd.second));
		nxt.invalid    = bad;
	end

	always_ff @(posedge clk) begin
		if (en)
			terms_s2 <= nxt;
	end

endmodule : c2e_scale
`default_nettype wire

// File: hw/rtl/c2e_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2e_sum
// Final stage: adds the scaled terms into the 32-bit epoch count, forcing
// zero on an invalid reading.
// ----------------------------------------------------------------------------
module c2e_sum
	import c2e_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire terms_t             terms,
	output logic [EpochW-1:0]       epoch_s3,
	output logic                    invalid_s3
);

	logic [EpochW-1:0] total;

	always_comb begin
		total = terms.year_secs + EpochW'(terms.month_secs) + EpochW'(terms.day_secs)
			+ EpochW'(terms.tod_secs);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			epoch_s3   <= terms.invalid ? '0 : total;
			invalid_s3 <= terms.invalid;
		end
	end

endmodule : c2e_sum
`default_nettype wire

// File: hw/rtl/c2e_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2e_checker
// Port-level checks for the calendar to epoch seconds converter.
// ----------------------------------------------------------------------------
module c2e_checker
	import c2e_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [EpochW-1:0]  m_tdata,
	input wire logic               m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// an invalid reading reports zero seconds
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("invalid result with nonzero seconds");

	// a ready receiver never stalls the input side
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// an accepted item reaches the output when unstalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready |=> ##1 m_tvalid)
		else $error("result missing after accepted item");

endmodule : c2e_checker

bind calendar_to_epoch_seconds_top c2e_checker u_c2e_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
